// ===== sv/pbg_pkg.sv =====
// ----------------------------------------------------------------------------
// pbg_pkg
// Shared types, constants and LFSR helpers for the PRBS BPSK bit generator.
// ----------------------------------------------------------------------------
package pbg_pkg;

    localparam int PHASE_BITS  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int SR_BITS     = 31;
    localparam int POLY_W      = 3;
    localparam int STEP_W      = 33;
    localparam int AMP_W       = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 33;

    localparam logic [31:0] AMP_MAX = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP  = 2'd2;

    // polynomial select codes
    localparam logic [POLY_W-1:0] POLY_PRBS7  = 3'd0;
    localparam logic [POLY_W-1:0] POLY_PRBS9  = 3'd1;
    localparam logic [POLY_W-1:0] POLY_PRBS11 = 3'd2;
    localparam logic [POLY_W-1:0] POLY_PRBS15 = 3'd3;
    localparam logic [POLY_W-1:0] POLY_PRBS23 = 3'd4;
    localparam logic [POLY_W-1:0] POLY_PRBS31 = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_i;
        logic                          data_bit;
    } result_t;

    // feedback mask: bits n-1 and n-1-t of x^n + x^t + 1
    function automatic logic [SR_BITS-1:0] tap_mask(input logic [POLY_W-1:0] sel);
        logic [SR_BITS-1:0] m;
        unique case (sel)
            POLY_PRBS7:  m = 31'h0000_0041;
            POLY_PRBS9:  m = 31'h0000_0108;
            POLY_PRBS11: m = 31'h0000_0402;
            POLY_PRBS23: m = 31'h0040_0010;
            POLY_PRBS31: m = 31'h4000_0004;
            default:     m = 31'h0000_4001;  // PRBS15, also unused codes
        endcase
        return m;
    endfunction

    function automatic logic [SR_BITS-1:0] seed_ones(input logic [POLY_W-1:0] sel);
        logic [SR_BITS-1:0] s;
        unique case (sel)
            POLY_PRBS7:  s = 31'h0000_007F;
            POLY_PRBS9:  s = 31'h0000_01FF;
            POLY_PRBS11: s = 31'h0000_07FF;
            POLY_PRBS23: s = 31'h007F_FFFF;
            POLY_PRBS31: s = 31'h7FFF_FFFF;
            default:     s = 31'h0000_7FFF;
        endcase
        return s;
    endfunction

    function automatic logic [SR_BITS-1:0] lfsr_next(input logic [SR_BITS-1:0] sr,
                                                     input logic [POLY_W-1:0]  sel);
        return (sr >> 1) ^ (sr[0] ? tap_mask(sel) : '0);
    endfunction

    // register contents after seeding with ones and one step
    function automatic logic [SR_BITS-1:0] seed_state(input logic [POLY_W-1:0] sel);
        return lfsr_next(seed_ones(sel), sel);
    endfunction

endpackage

// ===== sv/pbg_out_buf.sv =====
// ----------------------------------------------------------------------------
// pbg_out_buf
// Output register with one skid entry; frees the input side while a sample
// waits on a stalled receiver.
// ----------------------------------------------------------------------------
module pbg_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pbg_pkg::result_t push_data,
    output logic            full,
    output logic            out_valid,
    input  logic            out_stall,
    output pbg_pkg::result_t out_data
);
    import pbg_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_fire;

    assign out_fire  = out_valid_reg & ~out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // input side is held off, so no push here
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== sv/prbs_bpsk_bit_generator_core.sv =====
// ----------------------------------------------------------------------------
// prbs_bpsk_bit_generator_core
// PRBS-driven BPSK sample source with a fractional bit-rate accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries restart and advance. Each
//   accepted request with advance set yields one result on the output
//   channel (out_valid/out_stall): sample_i = +/-amplitude (0 when the bit
//   step is zero) and data_bit, the PRBS bit carried by that sample.
//   A request with only restart set reseeds the LFSR and yields nothing.
//   Result: registered in the output register, or in the skid entry while
//   the output is stalled. Throughput: one request per cycle while in_stall
//   is low; the phase add, the carry and one LFSR step are all combinational
//   between request and state registers.
//   Stall: a stalled result sits in the output register, one more request
//   lands in the skid entry, and in_stall rises only while that entry is
//   occupied.
//   Reset: polynomial PRBS15, bit step 0, amplitude 16384, LFSR seeded with
//   ones and stepped once, phase zero, output channel empty.
//   Configuration: cfg_we/cfg_index/cfg_data, written while idle. Changing
//   polynomial_select reseeds exactly like a restart.
// ----------------------------------------------------------------------------
module prbs_bpsk_bit_generator_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [pbg_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [pbg_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    restart,
    input  logic                                    advance,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [pbg_pkg::SAMPLE_BITS-1:0]  sample_i,
    output logic                                    data_bit
);
    import pbg_pkg::*;

    localparam int EXT_W = (PHASE_BITS + 1 > STEP_W) ? PHASE_BITS + 1 : STEP_W;
    localparam logic [EXT_W-1:0] FULL_STEP = EXT_W'(1) << PHASE_BITS;

    logic [POLY_W-1:0]     poly_reg, poly_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [AMP_W-1:0]      amp_reg, amp_next;
    logic [SR_BITS-1:0]    sr_reg, sr_next;
    logic                  cur_bit_reg, cur_bit_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;

    logic                   in_accept;
    logic                   push;
    logic                   buf_full;
    result_t                res, out_res;
    logic [SR_BITS-1:0]     sr_base;
    logic                   cur_base;
    logic [PHASE_BITS-1:0]  phase_base;
    logic [EXT_W-1:0]       step_ext, step_sat, phase_sum;
    logic [31:0]            amp_ext, amp_sat;
    logic [SAMPLE_BITS-1:0] amp_s;

    assign in_stall  = buf_full;
    assign in_accept = in_valid & ~buf_full;

    assign step_ext = EXT_W'(step_reg);
    assign step_sat = (step_ext > FULL_STEP) ? FULL_STEP : step_ext;
    assign amp_ext  = 32'(amp_reg);
    assign amp_sat  = (amp_ext > AMP_MAX) ? AMP_MAX : amp_ext;
    assign amp_s    = amp_sat[SAMPLE_BITS-1:0];

    // restart acts before the sample of the same request
    always_comb
    begin
        if (restart)
        begin
            sr_base    = seed_state(poly_reg);
            cur_base   = 1'b1;
            phase_base = '0;
        end
        else
        begin
            sr_base    = sr_reg;
            cur_base   = cur_bit_reg;
            phase_base = phase_reg;
        end
    end

    assign phase_sum = EXT_W'(phase_base) + step_sat;

    always_comb
    begin
        poly_next    = poly_reg;
        step_next    = step_reg;
        amp_next     = amp_reg;
        sr_next      = sr_reg;
        cur_bit_next = cur_bit_reg;
        phase_next   = phase_reg;
        push         = 1'b0;
        res.data_bit = cur_base;
        res.sample_i = cur_base ? $signed(amp_s) : -$signed(amp_s);

        if (in_accept)
        begin
            sr_next      = sr_base;
            cur_bit_next = cur_base;
            phase_next   = phase_base;
            if (advance)
            begin
                push = 1'b1;
                if (step_sat == '0)
                begin
                    res.sample_i = '0;
                end
                else
                begin
                    phase_next = phase_sum[PHASE_BITS-1:0];
                    // sum stays below two full turns: at most one new bit
                    if (phase_sum[PHASE_BITS])
                    begin
                        cur_bit_next = sr_base[0];
                        sr_next      = lfsr_next(sr_base, poly_reg);
                    end
                end
            end
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLY:
                begin
                    if (cfg_data[POLY_W-1:0] != poly_reg)
                    begin
                        poly_next    = cfg_data[POLY_W-1:0];
                        sr_next      = seed_state(cfg_data[POLY_W-1:0]);
                        cur_bit_next = 1'b1;
                        phase_next   = '0;
                    end
                end
                CFG_STEP: step_next = cfg_data[STEP_W-1:0];
                CFG_AMP:  amp_next  = cfg_data[AMP_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg    <= POLY_PRBS15;
            step_reg    <= '0;
            amp_reg     <= AMP_W'(16384);
            sr_reg      <= seed_state(POLY_PRBS15);
            cur_bit_reg <= 1'b1;
            phase_reg   <= '0;
        end
        else
        begin
            poly_reg    <= poly_next;
            step_reg    <= step_next;
            amp_reg     <= amp_next;
            sr_reg      <= sr_next;
            cur_bit_reg <= cur_bit_next;
            phase_reg   <= phase_next;
        end
    end

    pbg_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign sample_i = out_res.sample_i;
    assign data_bit = out_res.data_bit;

`ifndef NO_ASSERTIONS
    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid entry occupied with empty output register");

    // generator state moves only on a request or a config write
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_accept && !cfg_we) |=> ($stable(sr_reg) && $stable(phase_reg)
                                     && $stable(cur_bit_reg)))
        else $error("generator state changed while idle");

    // a restart without advance leaves the freshly seeded state
    a_restart_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && restart && !advance && !cfg_we)
            |=> (cur_bit_reg && phase_reg == '0 && !$rose(out_valid)))
        else $error("restart did not reseed cleanly");
`endif

endmodule
